### hdl/mbx_pkg.sv
// Mailbox package: beat types, status and request codes.
// Used by rtos_mailbox_queue (not by mbx_ram); no dependencies.
package mbx_pkg;

	localparam int MSG_DEPTH_DEF  = 16;
	localparam int WAIT_DEPTH_DEF = 8;

	localparam logic [1:0] KIND_SEND  = 2'd0;
	localparam logic [1:0] KIND_RECV  = 2'd1;
	localparam logic [1:0] KIND_POLL  = 2'd2;
	localparam logic [1:0] KIND_DEL   = 2'd3;

	localparam logic [2:0] ST_QUEUED    = 3'd0;
	localparam logic [2:0] ST_DELIVERED = 3'd1;
	localparam logic [2:0] ST_WAITING   = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;
	localparam logic [2:0] ST_BUSY      = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	localparam logic CFG_MSG_BY_PRIO  = 1'b0;
	localparam logic CFG_WAIT_BY_PRIO = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] msg_handle;
		logic [7:0]  msg_priority;
		logic [7:0]  task_id;
		logic [7:0]  task_priority;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_msg_handle;
		logic [7:0]  out_msg_priority;
		logic [7:0]  out_task_id;
	} rsp_t;

endpackage

### hdl/rtos_mailbox_queue.sv
// Kernel mailbox: message store and waiting-task store, each a RAM.
// Depends on mbx_pkg and mbx_ram.
//
// One request beat yields one response beat. Sends into an empty waiter store,
// blocking receives that queue the caller, refused or empty requests and deletes
// go from acceptance straight to the finish state, which registers the response
// and then lets the next request be taken; while an earlier response is held by
// rsp_stall the finish state waits. A request that removes an entry holds the
// request side through a scan pass and a shift pass (one RAM read a cycle): in
// priority mode the scan reads every live entry for the minimum, in age order
// only the oldest; the shift pass then closes the gap. A new request is taken
// while the previous response still waits to be taken. Ties in priority go to
// the oldest entry; removal keeps age order.
module rtos_mailbox_queue #(
	parameter int MSG_DEPTH  = mbx_pkg::MSG_DEPTH_DEF,
	parameter int WAIT_DEPTH = mbx_pkg::WAIT_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mbx_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mbx_pkg::rsp_t rsp_data,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic          cfg_data
);
	import mbx_pkg::*;

	localparam int MAW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int MCW = $clog2(MSG_DEPTH + 1);
	localparam int WCW = $clog2(WAIT_DEPTH + 1);
	localparam int CW  = (MCW > WCW) ? MCW : WCW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;

	logic [2:0]     state_q;
	logic           msg_prio_q, wait_prio_q;
	logic [MCW-1:0] mcnt_q;
	logic [WCW-1:0] wcnt_q;
	req_t           req_q;
	logic [2:0]     status_q;
	logic           sel_wait_q;     // store being worked on
	logic [CW-1:0]  ra_q;           // next read address
	logic [CW-1:0]  lim_q;          // last entry the scan reads
	logic [CW-1:0]  last_q;         // last live entry
	logic           rv_s1;          // read data valid this cycle
	logic [CW-1:0]  ri_s1;          // its address
	logic [CW-1:0]  best_idx_q;
	logic [23:0]    best_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	// RAM ports
	logic           m_we, w_we;
	logic [MAW-1:0] m_waddr;
	logic [WAW-1:0] w_waddr;
	logic [23:0]    m_wdata, m_rdata;
	logic [15:0]    w_wdata, w_rdata;
	logic [23:0]    wr_word;
	logic [CW-1:0]  wr_addr;
	logic [23:0]    rd_word;

	logic           accept, scan_iss, sh_iss, rd_iss, better;
	logic [CW-1:0]  nbest_idx;
	logic [23:0]    nbest;
	logic [CW-1:0]  cnt_sel;
	logic           use_prio;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign rd_word  = sel_wait_q ? {8'h00, w_rdata} : m_rdata;
	assign scan_iss = (state_q == S_SCAN) && (ra_q <= lim_q);
	assign sh_iss   = (state_q == S_SHIFT) && (ra_q <= last_q);
	assign rd_iss   = scan_iss || sh_iss;

	// Running minimum; first entry always seeds it, strict compare keeps oldest.
	assign better    = (ri_s1 == '0) || (rd_word[7:0] < best_q[7:0]);
	assign nbest_idx = (rv_s1 && better) ? ri_s1 : best_idx_q;
	assign nbest     = (rv_s1 && better) ? rd_word : best_q;

	// Write port: append on accept, or close the gap during the shift pass.
	always_comb begin
		m_we    = 1'b0;
		w_we    = 1'b0;
		wr_word = '0;
		wr_addr = '0;
		if (state_q == S_IDLE && accept) begin
			if (req_data.kind == KIND_SEND && wcnt_q == '0
			    && mcnt_q < MCW'(MSG_DEPTH)) begin
				m_we    = 1'b1;
				wr_addr = CW'(mcnt_q);
				wr_word = {req_data.msg_handle, req_data.msg_priority};
			end else if (req_data.kind == KIND_RECV && mcnt_q == '0
			             && wcnt_q < WCW'(WAIT_DEPTH)) begin
				w_we    = 1'b1;
				wr_addr = CW'(wcnt_q);
				wr_word = {8'h00, req_data.task_id, req_data.task_priority};
			end
		end else if (state_q == S_SHIFT && rv_s1) begin
			m_we    = !sel_wait_q;
			w_we    = sel_wait_q;
			wr_addr = ri_s1 - CW'(1);
			wr_word = rd_word;
		end
	end

	assign m_waddr = wr_addr[MAW-1:0];
	assign w_waddr = wr_addr[WAW-1:0];
	assign m_wdata = wr_word;
	assign w_wdata = wr_word[15:0];

	mbx_ram #(.WIDTH(24), .DEPTH(MSG_DEPTH)) u_msg_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (ra_q[MAW-1:0]),
		.rdata (m_rdata)
	);

	mbx_ram #(.WIDTH(16), .DEPTH(WAIT_DEPTH)) u_wait_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (ra_q[WAW-1:0]),
		.rdata (w_rdata)
	);

	// Which store a removal works on, and its mode.
	always_comb begin
		if (req_data.kind == KIND_SEND) begin
			cnt_sel  = CW'(wcnt_q);
			use_prio = wait_prio_q;
		end else begin
			cnt_sel  = CW'(mcnt_q);
			use_prio = msg_prio_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
		end
		if (state_q == S_SCAN && rv_s1) begin
			best_q <= nbest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			msg_prio_q  <= 1'b0;
			wait_prio_q <= 1'b0;
			mcnt_q      <= '0;
			wcnt_q      <= '0;
			status_q    <= ST_QUEUED;
			sel_wait_q  <= 1'b0;
			ra_q        <= '0;
			lim_q       <= '0;
			last_q      <= '0;
			rv_s1       <= 1'b0;
			ri_s1       <= '0;
			best_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MSG_BY_PRIO) begin
					msg_prio_q <= cfg_data;
				end else begin
					wait_prio_q <= cfg_data;
				end
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rv_s1 <= rd_iss;
			ri_s1 <= ra_q;
			if (rd_iss) begin
				ra_q <= ra_q + CW'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FIN;
						ra_q    <= '0;
						sel_wait_q <= (req_data.kind == KIND_SEND);
						lim_q   <= use_prio ? cnt_sel - CW'(1) : '0;
						last_q  <= cnt_sel - CW'(1);
						case (req_data.kind)
							KIND_SEND: begin
								if (wcnt_q != '0) begin
									state_q  <= S_SCAN;
									status_q <= ST_DELIVERED;
								end else if (mcnt_q >= MCW'(MSG_DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									mcnt_q   <= mcnt_q + MCW'(1);
									status_q <= ST_QUEUED;
								end
							end
							KIND_RECV, KIND_POLL: begin
								if (mcnt_q != '0) begin
									state_q  <= S_SCAN;
									status_q <= ST_DELIVERED;
								end else if (req_data.kind == KIND_POLL) begin
									status_q <= ST_EMPTY;
								end else if (wcnt_q >= WCW'(WAIT_DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									wcnt_q   <= wcnt_q + WCW'(1);
									status_q <= ST_WAITING;
								end
							end
							default: begin
								status_q <= (mcnt_q != '0 || wcnt_q != '0)
								            ? ST_BUSY : ST_CLEARED;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rv_s1) begin
						best_idx_q <= nbest_idx;
						if (ri_s1 == lim_q) begin
							// shift pass starts just past the chosen entry
							state_q <= S_SHIFT;
							ra_q    <= nbest_idx + CW'(1);
							rv_s1   <= 1'b0;
						end
					end
				end
				S_SHIFT: begin
					if (!sh_iss && !rv_s1) begin
						state_q <= S_FIN;
						if (sel_wait_q) begin
							wcnt_q <= wcnt_q - WCW'(1);
						end else begin
							mcnt_q <= mcnt_q - MCW'(1);
						end
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q                <= S_IDLE;
						rsp_valid_q            <= 1'b1;
						rsp_q.status           <= status_q;
						rsp_q.out_msg_handle   <= '0;
						rsp_q.out_msg_priority <= '0;
						rsp_q.out_task_id      <= '0;
						if (status_q == ST_DELIVERED) begin
							if (sel_wait_q) begin
								rsp_q.out_msg_handle   <= req_q.msg_handle;
								rsp_q.out_msg_priority <= req_q.msg_priority;
								rsp_q.out_task_id      <= best_q[15:8];
							end else begin
								rsp_q.out_msg_handle   <= best_q[23:8];
								rsp_q.out_msg_priority <= best_q[7:0];
								rsp_q.out_task_id      <= req_q.task_id;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

### hdl/mbx_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mbx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
